### design/fecinv_pkg.sv
// ----------------------------------------------------------------------------
// Face-element connectivity inverter package
// Shared payload types, request codes and the controller-to-datapath command
// and status types.
// ----------------------------------------------------------------------------
package fecinv_pkg;

	// Request codes carried in req_type.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// One input item.
	typedef struct packed {
		logic        req_type;
		logic [10:0] left_element;
		logic [10:0] right_element;
		logic        last_face;
		logic [13:0] read_index;
	} in_t;

	// One result item.
	typedef struct packed {
		logic [13:0] out_word;
		logic [13:0] list_length;
		logic        range_error;
	} out_t;

	// Datapath operations, one per cycle.
	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_RD_ISSUE,
		CMD_RD_DONE,
		CMD_CLR,
		CMD_IDX_RST,
		CMD_FACE_RD,
		CMD_CNT_RD,
		CMD_CNT_WR,
		CMD_PFX_RD,
		CMD_PFX_WR,
		CMD_TOTAL,
		CMD_SCT_RD,
		CMD_SCT_WR,
		CMD_FINISH
	} cmd_t;

	// Command bundle from the controller.
	typedef struct packed {
		cmd_t cmd;
		logic side;
	} ctl_t;

	// Status bundle back to the controller.
	typedef struct packed {
		logic idx_end;
		logic face_end;
	} stat_t;

endpackage

### design/fecinv_datapath.sv
// ----------------------------------------------------------------------------
// Face-element connectivity inverter datapath
// Holds the face store, the count and position tables, the list memory and
// all counters. Executes one command from the controller per cycle.
// ----------------------------------------------------------------------------
module fecinv_datapath #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int MAX_FACES    = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [10:0]       cfg_data,
	input  fecinv_pkg::ctl_t  ctl,
	input  fecinv_pkg::in_t   in_data,
	output fecinv_pkg::stat_t status,
	output fecinv_pkg::out_t  out_data
);

	localparam int LIST_DEPTH = MAX_ELEMENTS + 2 * MAX_FACES;
	localparam int AE = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int AF = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
	localparam int AL = $clog2(LIST_DEPTH);
	localparam int EW = $clog2(MAX_ELEMENTS + 1);
	localparam int FW = $clog2(MAX_FACES + 1);
	localparam int LW = $clog2(LIST_DEPTH + 1);
	localparam int CW = $clog2(2 * MAX_FACES + 1);
	localparam int XW = (EW > 11) ? EW : 11;
	localparam int RW = (LW > 14) ? LW : 14;

	// Memories.
	logic [21:0]   face_mem [MAX_FACES];
	logic [CW-1:0] cnt_mem  [MAX_ELEMENTS];
	logic [LW-1:0] pos_mem  [MAX_ELEMENTS];
	logic [13:0]   list_mem [LIST_DEPTH];

	logic [10:0]   elem_cnt_q;
	logic [FW-1:0] faces_q;
	logic          built_q;
	logic [LW-1:0] total_q;
	logic          err_q;
	logic [EW-1:0] idx_q;
	logic [FW-1:0] fptr_q;
	logic [LW-1:0] pos_q;
	logic          rd_hit_q;
	logic          sv_q;
	logic [AE-1:0] slot_q;
	fecinv_pkg::out_t out_q;

	logic [21:0]   pair_rd_q;
	logic [CW-1:0] cnt_rd_q;
	logic [LW-1:0] pos_rd_q;
	logic [13:0]   list_rd_q;

	logic [EW-1:0] eff_n;
	logic [10:0]   raw;
	logic          in_rng;
	logic          sel_ok;
	logic          sel_bad;
	logic [AE-1:0] slot;
	logic [FW-1:0] fbase;
	logic          room;
	logic          rd_hit;
	logic [LW:0]   sct_idx;
	logic [AE-1:0] cnt_addr;

	// Element count saturated to the table size.
	always_comb begin
		if (XW'(elem_cnt_q) > XW'(MAX_ELEMENTS)) begin
			eff_n = EW'(MAX_ELEMENTS);
		end else begin
			eff_n = EW'(elem_cnt_q);
		end
	end

	assign status.idx_end  = (idx_q == eff_n);
	assign status.face_end = (fptr_q == faces_q);

	// Neighbor selection and range check for the current side.
	assign raw     = ctl.side ? pair_rd_q[21:11] : pair_rd_q[10:0];
	assign in_rng  = XW'(raw) <= XW'(eff_n);
	assign sel_ok  = (raw != 11'd0) && in_rng;
	assign sel_bad = (raw != 11'd0) && !in_rng;
	assign slot    = AE'(XW'(raw) - XW'(1));

	// Load slot; a load after a finished build starts a new set.
	assign fbase = built_q ? '0 : faces_q;
	assign room  = fbase < FW'(MAX_FACES);

	// Read range check.
	assign rd_hit = built_q && (RW'(in_data.read_index) < RW'(total_q));

	// Scatter position of the next face of an element.
	assign sct_idx = (LW+1)'(pos_rd_q) + (LW+1)'(cnt_rd_q) + (LW+1)'(1);

	// Count table address.
	always_comb begin
		if (ctl.cmd == fecinv_pkg::CMD_CNT_RD || ctl.cmd == fecinv_pkg::CMD_SCT_RD) begin
			cnt_addr = slot;
		end else if (ctl.cmd == fecinv_pkg::CMD_CNT_WR || ctl.cmd == fecinv_pkg::CMD_SCT_WR) begin
			cnt_addr = slot_q;
		end else begin
			cnt_addr = idx_q[AE-1:0];
		end
	end

	// Face store.
	always_ff @(posedge clk) begin
		if (ctl.cmd == fecinv_pkg::CMD_LOAD && room) begin
			face_mem[fbase[AF-1:0]] <= {in_data.right_element, in_data.left_element};
		end
		if (ctl.cmd == fecinv_pkg::CMD_FACE_RD) begin
			pair_rd_q <= face_mem[fptr_q[AF-1:0]];
		end
	end

	// Count table.
	always_ff @(posedge clk) begin
		if (ctl.cmd == fecinv_pkg::CMD_CLR) begin
			cnt_mem[cnt_addr] <= '0;
		end else if ((ctl.cmd == fecinv_pkg::CMD_CNT_WR || ctl.cmd == fecinv_pkg::CMD_SCT_WR)
				&& sv_q) begin
			cnt_mem[cnt_addr] <= cnt_rd_q + CW'(1);
		end
		cnt_rd_q <= cnt_mem[cnt_addr];
	end

	// Position table.
	always_ff @(posedge clk) begin
		if (ctl.cmd == fecinv_pkg::CMD_PFX_WR) begin
			pos_mem[idx_q[AE-1:0]] <= pos_q;
		end
		if (ctl.cmd == fecinv_pkg::CMD_SCT_RD) begin
			pos_rd_q <= pos_mem[slot];
		end
	end

	// List memory: count words during the prefix pass, face numbers in scatter.
	always_ff @(posedge clk) begin
		if (ctl.cmd == fecinv_pkg::CMD_PFX_WR && pos_q < LW'(LIST_DEPTH)) begin
			list_mem[pos_q[AL-1:0]] <= 14'(cnt_rd_q);
		end else if (ctl.cmd == fecinv_pkg::CMD_SCT_WR && sv_q
				&& sct_idx < (LW+1)'(LIST_DEPTH)) begin
			list_mem[sct_idx[AL-1:0]] <= 14'(fptr_q + FW'(1));
		end
		if (ctl.cmd == fecinv_pkg::CMD_RD_ISSUE) begin
			list_rd_q <= list_mem[AL'(in_data.read_index)];
		end
	end

	// Slot capture and result payload.
	always_ff @(posedge clk) begin
		if (ctl.cmd == fecinv_pkg::CMD_CNT_RD || ctl.cmd == fecinv_pkg::CMD_SCT_RD) begin
			sv_q   <= sel_ok;
			slot_q <= slot;
		end
		if (ctl.cmd == fecinv_pkg::CMD_RD_ISSUE) begin
			rd_hit_q <= rd_hit;
		end
		if (ctl.cmd == fecinv_pkg::CMD_RD_DONE) begin
			out_q.out_word    <= rd_hit_q ? list_rd_q : 14'd0;
			out_q.list_length <= 14'(total_q);
			out_q.range_error <= !rd_hit_q;
		end else if (ctl.cmd == fecinv_pkg::CMD_FINISH) begin
			out_q.out_word    <= 14'd0;
			out_q.list_length <= 14'(total_q);
			out_q.range_error <= err_q;
		end
	end

	assign out_data = out_q;

	// Set state, counters and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= 11'd1;
			faces_q    <= '0;
			built_q    <= 1'b0;
			total_q    <= '0;
			err_q      <= 1'b0;
			idx_q      <= '0;
			fptr_q     <= '0;
			pos_q      <= '0;
		end else begin
			if (cfg_we) begin
				elem_cnt_q <= cfg_data;
			end
			unique case (ctl.cmd)
				fecinv_pkg::CMD_LOAD: begin
					built_q <= 1'b0;
					idx_q   <= '0;
					fptr_q  <= '0;
					if (built_q) begin
						total_q <= '0;
					end
					if (room) begin
						faces_q <= fbase + FW'(1);
						err_q   <= built_q ? 1'b0 : err_q;
					end else begin
						faces_q <= fbase;
						err_q   <= 1'b1;
					end
				end
				fecinv_pkg::CMD_CLR: begin
					idx_q <= idx_q + EW'(1);
				end
				fecinv_pkg::CMD_IDX_RST: begin
					idx_q  <= '0;
					fptr_q <= '0;
					pos_q  <= '0;
				end
				fecinv_pkg::CMD_CNT_RD: begin
					if (sel_bad) begin
						err_q <= 1'b1;
					end
				end
				fecinv_pkg::CMD_CNT_WR, fecinv_pkg::CMD_SCT_WR: begin
					if (ctl.side) begin
						fptr_q <= fptr_q + FW'(1);
					end
				end
				fecinv_pkg::CMD_PFX_WR: begin
					pos_q <= pos_q + LW'(cnt_rd_q) + LW'(1);
					idx_q <= idx_q + EW'(1);
				end
				fecinv_pkg::CMD_TOTAL: begin
					total_q <= pos_q;
					idx_q   <= '0;
				end
				fecinv_pkg::CMD_FINISH: begin
					built_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### design/fecinv_ctrl.sv
// ----------------------------------------------------------------------------
// Face-element connectivity inverter controller
// Sequences loads, reads and the multi-pass build, and runs the handshakes.
// ----------------------------------------------------------------------------
module fecinv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic              last_face,
	output logic              out_valid,
	input  logic              out_stall,
	input  fecinv_pkg::stat_t status,
	output fecinv_pkg::ctl_t  ctl
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CLR1, S_RST1, S_CNT_F, S_CNT_R, S_CNT_W, S_PFX_R,
		S_PFX_W, S_CLR2, S_RST2, S_SCT_F, S_SCT_R, S_SCT_W, S_FIN, S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   side_q;
	logic   side_d;
	logic   in_xfer;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign in_xfer   = in_valid && !in_stall;
	assign ctl.side  = side_q;

	// Command and next-state decode.
	always_comb begin
		state_d = state_q;
		side_d  = side_q;
		ctl.cmd = fecinv_pkg::CMD_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (req_type == fecinv_pkg::REQ_READ) begin
						ctl.cmd = fecinv_pkg::CMD_RD_ISSUE;
						state_d = S_RD;
					end else begin
						ctl.cmd = fecinv_pkg::CMD_LOAD;
						if (last_face) begin
							state_d = S_CLR1;
						end
					end
				end
			end
			S_RD: begin
				ctl.cmd = fecinv_pkg::CMD_RD_DONE;
				state_d = S_RESP;
			end
			S_CLR1, S_CLR2: begin
				if (status.idx_end) begin
					ctl.cmd = fecinv_pkg::CMD_IDX_RST;
					state_d = (state_q == S_CLR1) ? S_CNT_F : S_SCT_F;
				end else begin
					ctl.cmd = fecinv_pkg::CMD_CLR;
				end
			end
			S_CNT_F, S_SCT_F: begin
				if (status.face_end) begin
					state_d = (state_q == S_CNT_F) ? S_PFX_R : S_FIN;
				end else begin
					ctl.cmd = fecinv_pkg::CMD_FACE_RD;
					side_d  = 1'b0;
					state_d = (state_q == S_CNT_F) ? S_CNT_R : S_SCT_R;
				end
			end
			S_CNT_R: begin
				ctl.cmd = fecinv_pkg::CMD_CNT_RD;
				state_d = S_CNT_W;
			end
			S_SCT_R: begin
				ctl.cmd = fecinv_pkg::CMD_SCT_RD;
				state_d = S_SCT_W;
			end
			S_CNT_W, S_SCT_W: begin
				ctl.cmd = (state_q == S_CNT_W) ? fecinv_pkg::CMD_CNT_WR : fecinv_pkg::CMD_SCT_WR;
				if (side_q) begin
					state_d = (state_q == S_CNT_W) ? S_CNT_F : S_SCT_F;
				end else begin
					side_d  = 1'b1;
					state_d = (state_q == S_CNT_W) ? S_CNT_R : S_SCT_R;
				end
			end
			S_PFX_R: begin
				if (status.idx_end) begin
					ctl.cmd = fecinv_pkg::CMD_TOTAL;
					state_d = S_CLR2;
				end else begin
					ctl.cmd = fecinv_pkg::CMD_PFX_RD;
					state_d = S_PFX_W;
				end
			end
			S_PFX_W: begin
				ctl.cmd = fecinv_pkg::CMD_PFX_WR;
				state_d = S_PFX_R;
			end
			S_RST1, S_RST2: begin
				ctl.cmd = fecinv_pkg::CMD_IDX_RST;
				state_d = (state_q == S_RST1) ? S_CNT_F : S_SCT_F;
			end
			S_FIN: begin
				ctl.cmd = fecinv_pkg::CMD_FINISH;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
		end
	end

endmodule

### design/face_element_connectivity_inverter.sv
// ----------------------------------------------------------------------------
// Face-element connectivity inverter
// Builds an element-to-face list from per-face neighbor pairs.
// ----------------------------------------------------------------------------
// Loads are taken one per cycle and return no result, except the load marked
// last, which starts the build and returns one status transfer when it is
// done. A read issues its list-memory access, then registers the word for
// the output transfer. The build runs with input stalled, one memory access
// per cycle through a single count-table port: two clearing sweeps and a
// prefix pass over the elements, and two passes over the faces, each reading
// a face and then reading and writing the count of each side. The block takes
// one item at a time; input stalls while a result waits for transfer.
module face_element_connectivity_inverter #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int MAX_FACES    = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  fecinv_pkg::in_t  in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output fecinv_pkg::out_t out_data,
	input  logic             cfg_we,
	input  logic [10:0]      cfg_data
);

	fecinv_pkg::ctl_t  ctl;
	fecinv_pkg::stat_t status;

	// Sequencer.
	fecinv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (in_data.req_type),
		.last_face (in_data.last_face),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.ctl       (ctl)
	);

	// Storage and arithmetic.
	fecinv_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.MAX_FACES    (MAX_FACES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.ctl      (ctl),
		.in_data  (in_data),
		.status   (status),
		.out_data (out_data)
	);

endmodule
